[hw/rtl/second_chance_block_cache_tags_defines.svh]
// Assertion macros for the second-chance block cache tag engine.
// Used by second_chance_block_cache_tags.sv; needs clk and rst_n in scope.
`ifndef SECOND_CHANCE_BLOCK_CACHE_TAGS_DEFINES_SVH
`define SECOND_CHANCE_BLOCK_CACHE_TAGS_DEFINES_SVH

// same-cycle implication
`define SCCBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sccbt assertion failed");

// next-cycle implication
`define SCCBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sccbt assertion failed");

`endif

[hw/rtl/sccbt_pkg.sv]
// Shared types and codes of the second-chance block cache tag engine.
// No dependencies.
`timescale 1ns / 1ps

package sccbt_pkg;

    localparam int FILE_W  = 10;
    localparam int BLOCK_W = 32;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 32;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SYNC  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] KIND_ACCESS    = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_SYNC_DONE = 2'd2;
    localparam logic [1:0] KIND_CLEARED   = 2'd3;

    // one action applied to the selected cell
    typedef struct packed {
        logic alloc;
        logic dirty_val;
        logic set_ref;
        logic set_dirty;
        logic clr_ref;
        logic clr_dirty;
        logic kill;
    } cell_ctl_t;

    // ripple from cell to cell: lowest matching and lowest free entry
    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } cell_chain_t;

endpackage

[hw/rtl/sccbt_cell.sv]
// One cache entry: tag, referenced and dirty marks, plus its link in the
// lookup chain. Depends on sccbt_pkg.
`timescale 1ns / 1ps

module sccbt_cell
    import sccbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [FILE_W-1:0]  key_file,
    input  logic [BLOCK_W-1:0] key_block,
    input  cell_chain_t        chain_in,
    output cell_chain_t        chain_out,
    output logic               hit_here,
    output logic               free_here,
    output logic               valid,
    output logic               ref_mark,
    output logic               dirty,
    output logic [FILE_W-1:0]  file_tag,
    output logic [BLOCK_W-1:0] block_tag
);

    logic               valid_reg, valid_next;
    logic               ref_reg, ref_next;
    logic               dirty_reg, dirty_next;
    logic [FILE_W-1:0]  file_reg;
    logic [BLOCK_W-1:0] block_reg;
    logic               match;

    assign match = valid_reg && (file_reg == key_file) && (block_reg == key_block);

    assign hit_here            = match && !chain_in.hit_seen;
    assign free_here           = !valid_reg && !chain_in.free_seen;
    assign chain_out.hit_seen  = chain_in.hit_seen || match;
    assign chain_out.free_seen = chain_in.free_seen || !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        ref_next   = ref_reg;
        dirty_next = dirty_reg;
        priority if (ctl.kill)
        begin
            valid_next = 1'b0;
            ref_next   = 1'b0;
            dirty_next = 1'b0;
        end
        else if (ctl.alloc)
        begin
            valid_next = 1'b1;
            ref_next   = 1'b1;
            dirty_next = ctl.dirty_val;
        end
        else
        begin
            if (ctl.set_ref)   ref_next   = 1'b1;
            if (ctl.clr_ref)   ref_next   = 1'b0;
            if (ctl.set_dirty) dirty_next = 1'b1;
            if (ctl.clr_dirty) dirty_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ref_reg   <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ref_reg   <= ref_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.alloc)
        begin
            file_reg  <= key_file;
            block_reg <= key_block;
        end
    end

    assign valid     = valid_reg;
    assign ref_mark  = ref_reg;
    assign dirty     = dirty_reg;
    assign file_tag  = file_reg;
    assign block_tag = block_reg;

endmodule

[hw/rtl/second_chance_block_cache_tags.sv]
// Tag and replacement engine of a fully associative block cache, second-chance
// eviction over a FIFO ring. One item at a time: a hit or counter clear ends in
// the lookup, a miss runs lookup, eviction walk (full ring only) and allocation,
// a sync scans every cell then reports done, all waiting on output stalls; the
// walk visits one cell per cycle, the scan too unless a stalled writeback holds it.
// A registered output beat lets the result wait while the next item is taken
// once the engine is idle.
// Depends on sccbt_pkg, sccbt_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "second_chance_block_cache_tags_defines.svh"

module second_chance_block_cache_tags
    import sccbt_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic [FILE_W-1:0]  file_id,
    input  logic [BLOCK_W-1:0] block_number,
    input  logic               past_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic               hit,
    output logic               allocated,
    output logic [SLOT_W-1:0]  slot,
    output logic               writeback_valid,
    output logic [FILE_W-1:0]  writeback_file,
    output logic [BLOCK_W-1:0] writeback_block,
    output logic [CNT_W-1:0]   hit_total,
    output logic [CNT_W-1:0]   miss_total,
    output logic               last
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_EVICT  = 3'd2;
    localparam logic [2:0] ST_ALLOC  = 3'd3;
    localparam logic [2:0] ST_SYNC   = 3'd4;
    localparam logic [2:0] ST_SDONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [FILE_W-1:0]  file_reg, file_next;
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    logic               past_reg, past_next;

    logic               evicted_reg, evicted_next;
    logic [IW-1:0]      victim_reg, victim_next;
    logic               wbv_reg, wbv_next;
    logic [FILE_W-1:0]  wbf_reg, wbf_next;
    logic [BLOCK_W-1:0] wbb_reg, wbb_next;
    logic [IW-1:0]      scan_reg, scan_next;

    logic [IW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      ring_reg [SLOTS];
    logic               ring_we;
    logic [IW-1:0]      ring_widx;
    logic [IW-1:0]      ring_wdata;

    logic [CNT_W-1:0]   hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]   miss_cnt_reg, miss_cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic               hit_reg, hit_next;
    logic               alloc_reg, alloc_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               owbv_reg, owbv_next;
    logic [FILE_W-1:0]  owbf_reg, owbf_next;
    logic [BLOCK_W-1:0] owbb_reg, owbb_next;
    logic [CNT_W-1:0]   ohit_reg, ohit_next;
    logic [CNT_W-1:0]   omiss_reg, omiss_next;
    logic               last_reg, last_next;

    cell_ctl_t          act;
    logic [IW-1:0]      act_idx;
    cell_ctl_t          ctl [SLOTS];
    cell_chain_t        chain [SLOTS+1];
    logic [SLOTS-1:0]   c_hit, c_free, c_valid, c_ref, c_dirty;
    logic [FILE_W-1:0]  c_file [SLOTS];
    logic [BLOCK_W-1:0] c_block [SLOTS];

    logic [IW-1:0]      hit_idx, free_idx, sel_idx, head_inc, tail_idx, alloc_slot;
    logic [CW-1:0]      tail_sum;
    logic               can_emit, is_wr, do_alloc, sync_hit;

    assign chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        assign ctl[i] = (act_idx == IW'(i)) ? act : '0;
        sccbt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[i]),
            .key_file  (file_reg),
            .key_block (blk_reg),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .hit_here  (c_hit[i]),
            .free_here (c_free[i]),
            .valid     (c_valid[i]),
            .ref_mark  (c_ref[i]),
            .dirty     (c_dirty[i]),
            .file_tag  (c_file[i]),
            .block_tag (c_block[i])
        );
    end

    // hit_here and free_here are one-hot, so OR of indexes encodes them
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (c_hit[i])  hit_idx  = hit_idx  | IW'(i);
            if (c_free[i]) free_idx = free_idx | IW'(i);
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign can_emit = !out_valid_reg || !out_stall;
    assign is_wr    = (op_reg == OP_WRITE);
    assign sel_idx  = (state_reg == ST_SYNC) ? scan_reg : ring_reg[head_reg];
    assign head_inc = (head_reg == IW'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = {1'b0, head_reg} + count_reg;
    assign tail_idx = (tail_sum >= CW'(SLOTS)) ? IW'(tail_sum - CW'(SLOTS)) : tail_sum[IW-1:0];
    assign do_alloc = (is_wr || !past_reg) && (evicted_reg || chain[SLOTS].free_seen);
    assign alloc_slot = evicted_reg ? victim_reg : free_idx;
    assign sync_hit = c_valid[sel_idx] && (c_file[sel_idx] == file_reg) && c_dirty[sel_idx];

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        file_next    = file_reg;
        blk_next     = blk_reg;
        past_next    = past_reg;
        evicted_next = evicted_reg;
        victim_next  = victim_reg;
        wbv_next     = wbv_reg;
        wbf_next     = wbf_reg;
        wbb_next     = wbb_reg;
        scan_next    = scan_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        hit_cnt_next = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        ring_we      = 1'b0;
        ring_widx    = tail_idx;
        ring_wdata   = alloc_slot;
        act          = '0;
        act_idx      = '0;

        out_valid_next = out_valid_reg && out_stall;
        kind_next  = kind_reg;
        hit_next   = hit_reg;
        alloc_next = alloc_reg;
        slot_next  = slot_reg;
        owbv_next  = owbv_reg;
        owbf_next  = owbf_reg;
        owbb_next  = owbb_reg;
        ohit_next  = ohit_reg;
        omiss_next = omiss_reg;
        last_next  = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    file_next  = file_id;
                    blk_next   = block_number;
                    past_next  = past_end;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        if (can_emit)
                        begin
                            hit_cnt_next   = '0;
                            miss_cnt_next  = '0;
                            out_valid_next = 1'b1;
                            kind_next  = KIND_CLEARED;
                            hit_next   = 1'b0;
                            alloc_next = 1'b0;
                            slot_next  = '0;
                            owbv_next  = 1'b0;
                            owbf_next  = '0;
                            owbb_next  = '0;
                            ohit_next  = '0;
                            omiss_next = '0;
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    OP_SYNC:
                    begin
                        scan_next  = '0;
                        state_next = ST_SYNC;
                    end
                    default:
                    begin
                        if (chain[SLOTS].hit_seen)
                        begin
                            if (can_emit)
                            begin
                                if (hit_cnt_reg != '1)
                                    hit_cnt_next = hit_cnt_reg + 1'b1;
                                act.set_ref   = 1'b1;
                                act.set_dirty = is_wr;
                                act_idx       = hit_idx;
                                out_valid_next = 1'b1;
                                kind_next  = KIND_ACCESS;
                                hit_next   = 1'b1;
                                alloc_next = 1'b0;
                                slot_next  = SLOT_W'(hit_idx);
                                owbv_next  = 1'b0;
                                owbf_next  = '0;
                                owbb_next  = '0;
                                ohit_next  = hit_cnt_next;
                                omiss_next = miss_cnt_reg;
                                last_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            if (miss_cnt_reg != '1)
                                miss_cnt_next = miss_cnt_reg + 1'b1;
                            evicted_next = 1'b0;
                            victim_next  = '0;
                            wbv_next     = 1'b0;
                            wbf_next     = '0;
                            wbb_next     = '0;
                            state_next   = (count_reg == CW'(SLOTS)) ? ST_EVICT : ST_ALLOC;
                        end
                    end
                endcase
            end
            ST_EVICT:
            begin
                act_idx   = sel_idx;
                head_next = head_inc;
                if (c_valid[sel_idx] && c_ref[sel_idx])
                begin
                    // second chance: full ring, so rotation is a head advance
                    act.clr_ref = 1'b1;
                end
                else
                begin
                    act.kill     = 1'b1;
                    victim_next  = sel_idx;
                    evicted_next = 1'b1;
                    count_next   = count_reg - 1'b1;
                    if (c_valid[sel_idx] && c_dirty[sel_idx])
                    begin
                        wbv_next = 1'b1;
                        wbf_next = c_file[sel_idx];
                        wbb_next = c_block[sel_idx];
                    end
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                if (can_emit)
                begin
                    if (do_alloc)
                    begin
                        act.alloc     = 1'b1;
                        act.dirty_val = is_wr;
                        act_idx       = alloc_slot;
                        ring_we       = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    out_valid_next = 1'b1;
                    kind_next  = KIND_ACCESS;
                    hit_next   = 1'b0;
                    alloc_next = do_alloc;
                    slot_next  = do_alloc ? SLOT_W'(alloc_slot) : SLOT_W'(victim_reg);
                    owbv_next  = wbv_reg;
                    owbf_next  = wbf_reg;
                    owbb_next  = wbb_reg;
                    ohit_next  = hit_cnt_reg;
                    omiss_next = miss_cnt_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SYNC:
            begin
                if (!sync_hit || can_emit)
                begin
                    if (sync_hit)
                    begin
                        act.clr_dirty = 1'b1;
                        act_idx       = sel_idx;
                        out_valid_next = 1'b1;
                        kind_next  = KIND_WRITEBACK;
                        hit_next   = 1'b0;
                        alloc_next = 1'b0;
                        slot_next  = SLOT_W'(sel_idx);
                        owbv_next  = 1'b1;
                        owbf_next  = c_file[sel_idx];
                        owbb_next  = c_block[sel_idx];
                        ohit_next  = hit_cnt_reg;
                        omiss_next = miss_cnt_reg;
                        last_next  = 1'b0;
                    end
                    if (scan_reg == IW'(SLOTS - 1))
                        state_next = ST_SDONE;
                    else
                        scan_next = scan_reg + 1'b1;
                end
            end
            ST_SDONE:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    kind_next  = KIND_SYNC_DONE;
                    hit_next   = 1'b0;
                    alloc_next = 1'b0;
                    slot_next  = '0;
                    owbv_next  = 1'b0;
                    owbf_next  = '0;
                    owbb_next  = '0;
                    ohit_next  = hit_cnt_reg;
                    omiss_next = miss_cnt_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        file_reg    <= file_next;
        blk_reg     <= blk_next;
        past_reg    <= past_next;
        evicted_reg <= evicted_next;
        victim_reg  <= victim_next;
        wbv_reg     <= wbv_next;
        wbf_reg     <= wbf_next;
        wbb_reg     <= wbb_next;
        scan_reg    <= scan_next;
        kind_reg    <= kind_next;
        hit_reg     <= hit_next;
        alloc_reg   <= alloc_next;
        slot_reg    <= slot_next;
        owbv_reg    <= owbv_next;
        owbf_reg    <= owbf_next;
        owbb_reg    <= owbb_next;
        ohit_reg    <= ohit_next;
        omiss_reg   <= omiss_next;
        last_reg    <= last_next;
        if (ring_we)
            ring_reg[ring_widx] <= ring_wdata;
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign hit             = hit_reg;
    assign allocated       = alloc_reg;
    assign slot            = slot_reg;
    assign writeback_valid = owbv_reg;
    assign writeback_file  = owbf_reg;
    assign writeback_block = owbb_reg;
    assign hit_total       = ohit_reg;
    assign miss_total      = omiss_reg;
    assign last            = last_reg;

    `SCCBT_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(SLOTS))
    `SCCBT_ASSERT_IMP(a_evict_full, state_reg == ST_EVICT, count_reg == CW'(SLOTS))
    `SCCBT_ASSERT_NXT(a_accept_lookup, in_valid && !in_stall, state_reg == ST_LOOKUP)

endmodule

[tb/sv/second_chance_block_cache_tags_test.sv]
// Testbench for second_chance_block_cache_tags: random and directed cache accesses, syncs
// and clears, checked beat by beat against an in-bench second-chance predictor.
// Depends on sccbt_pkg and the second_chance_block_cache_tags RTL.
`timescale 1ns / 1ps

module second_chance_block_cache_tags_test;
    import sccbt_pkg::*;

    localparam int NSLOT = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]         op;
        logic [FILE_W-1:0]  fid;
        logic [BLOCK_W-1:0] blk;
        logic               past;
        logic               drain;
    } access_t;

    typedef struct {
        logic [1:0]         kind;
        logic               hit;
        logic               allocated;
        logic [SLOT_W-1:0]  slot;
        logic               wb_valid;
        logic [FILE_W-1:0]  wb_file;
        logic [BLOCK_W-1:0] wb_block;
        logic [CNT_W-1:0]   hits;
        logic [CNT_W-1:0]   misses;
        logic               last;
    } beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] opcode;
    logic [FILE_W-1:0] file_id;
    logic [BLOCK_W-1:0] block_number;
    logic past_end;
    logic out_valid;
    logic out_stall;
    logic [1:0] kind;
    logic hit;
    logic allocated;
    logic [SLOT_W-1:0] slot;
    logic writeback_valid;
    logic [FILE_W-1:0] writeback_file;
    logic [BLOCK_W-1:0] writeback_block;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic last;

    second_chance_block_cache_tags uut (.*);

    // predictor state
    logic               tag_valid [NSLOT];
    logic [FILE_W-1:0]  tag_file [NSLOT];
    logic [BLOCK_W-1:0] tag_block [NSLOT];
    logic               tag_ref [NSLOT];
    logic               tag_dirty [NSLOT];
    int                 fifo_ring [NSLOT];
    int                 fifo_head;
    int                 fifo_count;
    logic [CNT_W-1:0]   hit_cnt;
    logic [CNT_W-1:0]   miss_cnt;

    access_t pending_access[$];
    beat_t   expected_beats[$];
    int      error_count;
    int      cycle_count;
    int      accepted_count;
    int      hold_left;
    bit      hold_done;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic beat_t make_beat(input logic [1:0] k, input logic h, input logic a,
                                        input int s, input logic wv,
                                        input logic [FILE_W-1:0] wf,
                                        input logic [BLOCK_W-1:0] wb, input logic l);
        beat_t b;
        b.kind = k; b.hit = h; b.allocated = a; b.slot = s[SLOT_W-1:0];
        b.wb_valid = wv; b.wb_file = wf; b.wb_block = wb;
        b.hits = hit_cnt; b.misses = miss_cnt; b.last = l;
        return b;
    endfunction

    function automatic void expect_beat(input beat_t b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic void queue_access(input access_t a);
        pending_access = {pending_access, a};
    endfunction

    function automatic void bump(ref logic [CNT_W-1:0] c);
        if (c != '1)
            c = c + 1'b1;
    endfunction

    // second-chance walk; removes the victim from the ring
    function automatic int pick_victim();
        int s;
        s = 0;
        for (int n = 0; n < 2 * NSLOT + 1; n++)
        begin
            s = fifo_ring[fifo_head];
            if (tag_valid[s] && tag_ref[s])
            begin
                tag_ref[s] = 1'b0;
                fifo_ring[(fifo_head + fifo_count) % NSLOT] = s;
                fifo_head = (fifo_head + 1) % NSLOT;
            end
            else
                break;
        end
        fifo_head = (fifo_head + 1) % NSLOT;
        if (fifo_count > 0)
            fifo_count--;
        return s;
    endfunction

    function automatic void predict_cache(input access_t a);
        logic wr;
        logic evicted;
        logic wv;
        logic alloc;
        logic [FILE_W-1:0] wf;
        logic [BLOCK_W-1:0] wb;
        int victim;
        int s;
        int rslot;
        wr = (a.op == OP_WRITE);
        if (a.op == OP_CLEAR)
        begin
            hit_cnt = '0;
            miss_cnt = '0;
            expect_beat(make_beat(KIND_CLEARED, 0, 0, 0, 0, '0, '0, 1));
            return;
        end
        if (a.op == OP_SYNC)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (tag_valid[i] && tag_file[i] == a.fid && tag_dirty[i])
                begin
                    tag_dirty[i] = 1'b0;
                    expect_beat(make_beat(KIND_WRITEBACK, 0, 0, i, 1,
                                          tag_file[i], tag_block[i], 0));
                end
            expect_beat(make_beat(KIND_SYNC_DONE, 0, 0, 0, 0, '0, '0, 1));
            return;
        end
        for (int i = 0; i < NSLOT; i++)
            if (tag_valid[i] && tag_file[i] == a.fid && tag_block[i] == a.blk)
            begin
                bump(hit_cnt);
                tag_ref[i] = 1'b1;
                if (wr)
                    tag_dirty[i] = 1'b1;
                expect_beat(make_beat(KIND_ACCESS, 1, 0, i, 0, '0, '0, 1));
                return;
            end
        bump(miss_cnt);
        evicted = 0; wv = 0; alloc = 0; wf = '0; wb = '0; victim = 0; rslot = 0;
        if (fifo_count >= NSLOT)
        begin
            victim = pick_victim();
            evicted = 1;
            if (tag_valid[victim] && tag_dirty[victim])
            begin
                wv = 1; wf = tag_file[victim]; wb = tag_block[victim];
            end
            tag_valid[victim] = 0; tag_ref[victim] = 0; tag_dirty[victim] = 0;
        end
        if (wr || !a.past)
        begin
            s = NSLOT;
            if (evicted)
                s = victim;
            else
                for (int i = 0; i < NSLOT; i++)
                    if (!tag_valid[i])
                    begin
                        s = i;
                        break;
                    end
            if (s < NSLOT && fifo_count < NSLOT)
            begin
                tag_valid[s] = 1; tag_file[s] = a.fid; tag_block[s] = a.blk;
                tag_ref[s] = 1; tag_dirty[s] = wr;
                fifo_ring[(fifo_head + fifo_count) % NSLOT] = s;
                fifo_count++;
                alloc = 1;
                rslot = s;
            end
        end
        if (!alloc && evicted)
            rslot = victim;
        expect_beat(make_beat(KIND_ACCESS, 0, alloc, rslot, wv, wf, wb, 1));
    endfunction

    function automatic access_t mk(input logic [1:0] op, input logic [FILE_W-1:0] f,
                                   input logic [BLOCK_W-1:0] b, input logic p);
        access_t a;
        a.op = op; a.fid = f; a.blk = b; a.past = p; a.drain = 0;
        return a;
    endfunction

    function automatic access_t random_access();
        logic [FILE_W-1:0] files [4] = '{10'd0, 10'd3, 10'd512, 10'd1023};
        logic [BLOCK_W-1:0] blocks [12] = '{32'd0, 32'd1, 32'd2, 32'd7, 32'd100, 32'd4095,
                                            32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                                            32'hAAAA_AAAA, 32'd42, 32'h0001_0000};
        access_t a;
        int r;
        r = $urandom_range(0, 99);
        a.op = (r < 45) ? OP_READ : (r < 85) ? OP_WRITE : (r < 95) ? OP_SYNC : OP_CLEAR;
        a.fid = ($urandom_range(0, 9) == 0) ? FILE_W'($urandom) : files[$urandom_range(0, 3)];
        a.blk = ($urandom_range(0, 9) == 0) ? $urandom : blocks[$urandom_range(0, 11)];
        a.past = ($urandom_range(0, 4) == 0);
        a.drain = 0;
        return a;
    endfunction

    // driver
    always @(posedge clk)
    begin
        access_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_cache(pending_access[0]);
                pending_access.delete(0);
                accepted_count++;
            end
            if (in_valid && in_stall)
                ;   // hold the stalled beat
            else if (pending_access.size() > 0
                     && (!pending_access[0].drain || expected_beats.size() == 0)
                     && !((cycle_count < 2000 || cycle_count > 6000)
                          && $urandom_range(0, 99) < 6))
            begin
                nxt = pending_access[0];
                opcode <= nxt.op;
                file_id <= nxt.fid;
                block_number <= nxt.blk;
                past_end <= nxt.past;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && accepted_count >= 120)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (cycle_count < 2000 || cycle_count > 6000)
                         && ($urandom_range(0, 99) < 6);
    end

    // monitor
    always @(posedge clk)
    begin
        beat_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", {62'd0, kind}, '0);
            else
            begin
                w = expected_beats[0];
                expected_beats.delete(0);
                if (kind !== w.kind) report_mismatch("kind", kind, w.kind);
                if (hit !== w.hit) report_mismatch("hit", hit, w.hit);
                if (allocated !== w.allocated)
                    report_mismatch("allocated", allocated, w.allocated);
                if (slot !== w.slot) report_mismatch("slot", slot, w.slot);
                if (writeback_valid !== w.wb_valid)
                    report_mismatch("writeback_valid", writeback_valid, w.wb_valid);
                if (writeback_file !== w.wb_file)
                    report_mismatch("writeback_file", writeback_file, w.wb_file);
                if (writeback_block !== w.wb_block)
                    report_mismatch("writeback_block", writeback_block, w.wb_block);
                if (hit_total !== w.hits) report_mismatch("hit_total", hit_total, w.hits);
                if (miss_total !== w.misses)
                    report_mismatch("miss_total", miss_total, w.misses);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        access_t a;
        error_count = 0; cycle_count = 0; accepted_count = 0;
        hold_left = 0; hold_done = 0;
        fifo_head = 0; fifo_count = 0; hit_cnt = '0; miss_cnt = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            tag_valid[i] = 0; tag_ref[i] = 0; tag_dirty[i] = 0;
            tag_file[i] = '0; tag_block[i] = '0; fifo_ring[i] = 0;
        end
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
        opcode = OP_READ; file_id = '0; block_number = '0; past_end = 1'b0;

        // directed
        queue_access(mk(OP_READ, 10'd0, 32'd0, 0));
        queue_access(mk(OP_READ, 10'd0, 32'd0, 0));
        queue_access(mk(OP_WRITE, 10'd0, 32'd0, 0));
        queue_access(mk(OP_WRITE, 10'd1023, 32'hFFFF_FFFF, 1));
        queue_access(mk(OP_READ, 10'd5, 32'd9, 1));      // past end, no alloc
        queue_access(mk(OP_READ, 10'd1023, 32'hFFFF_FFFF, 1));
        queue_access(mk(OP_SYNC, 10'd0, 32'd0, 0));
        queue_access(mk(OP_SYNC, 10'd77, 32'd0, 0));      // nothing dirty
        queue_access(mk(OP_CLEAR, 10'd0, 32'd0, 0));
        // fill the cache, then miss on a full cache
        for (int i = 0; i < 31; i++)
            queue_access(mk(OP_WRITE, 10'd3, 32'(i + 100), 0));
        queue_access(mk(OP_READ, 10'd2, 32'd5, 1));      // full, evicts only
        queue_access(mk(OP_READ, 10'd2, 32'd6, 0));
        queue_access(mk(OP_SYNC, 10'd3, 32'd0, 0));      // many writebacks
        queue_access(mk(OP_SYNC, 10'd1023, 32'd0, 0));

        for (int i = 0; i < 216; i++)
        begin
            a = random_access();
            if (i == 150)
                a.drain = 1;
            queue_access(a);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_access.size() == 0 && expected_beats.size() == 0);
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
